[sv/wsfd_pkg.sv]
// wsfd_pkg: types and constants shared by the websocket deframer modules
// no dependencies; compile first
`default_nettype none

package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_B0  = 3'd0,
      PH_B1  = 3'd1,
      PH_EXT = 3'd2,
      PH_KEY = 3'd3,
      PH_PAY = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_CLOSE  = 2'd2
   } kind_type;

   // csr register indexes
   localparam logic CSR_UNMASK = 1'b0;
   localparam logic CSR_CHECK  = 1'b1;

   localparam logic [3:0] OP_FIRST_RSVD = 4'h3;
   localparam logic [3:0] OP_LAST_RSVD  = 4'h7;
   localparam logic [3:0] OP_CLOSE      = 4'h8;
   localparam logic [3:0] OP_MAX        = 4'hA;

   localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
   localparam logic [6:0] LEN_EXT16     = 7'd126;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   // one parsed word handed from the front to the back
   typedef struct packed {
      kind_type    kind;
      logic        fin;
      logic [2:0]  rsv_bits;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [7:0]  data_byte;
      logic        last;
      logic        frame_error;
      logic        close_valid;
      logic [15:0] status_code;
   } event_type;

   localparam int EVENT_W = $bits(event_type);

endpackage

`default_nettype wire

[sv/websocket_frame_deframer_core.sv]
// WebSocket frame deframer: takes one stream byte per cycle on req and
// gives header, payload and close-status words on rsp. A byte is taken
// every cycle unless the queue of QUEUE_DEPTH parsed words is full; the
// front updates its parse state and unmasks within the cycle of the byte.
// The second payload byte of a close frame yields two rsp words, which the
// back presents one after the other. Each word is registered in the queue
// and then the rsp output register. csr index 0 is unmask_enable and index
// 1 is check_enable, both reset to 1; write them only while idle.
// Depends on wsfd_pkg, wsfd_front, wsfd_queue and wsfd_back.
`default_nettype none

module websocket_frame_deframer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic             rsp_fin,
   output logic [2:0]       rsp_rsv_bits,
   output logic [3:0]       rsp_opcode,
   output logic             rsp_masked,
   output logic [63:0]      rsp_payload_length,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last,
   output logic [15:0]      rsp_status_code,
   output logic             rsp_frame_error,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata
);

   logic                              accept;
   logic                              push;
   logic                              pop;
   logic                              q_full;
   logic                              q_empty;
   wsfd_pkg::event_type               push_event;
   wsfd_pkg::event_type               head_event;
   logic [wsfd_pkg::EVENT_W-1:0]      q_head;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign head_event = wsfd_pkg::event_type'(q_head);

   wsfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_event (push_event)
   );

   wsfd_queue #(
      .WIDTH (wsfd_pkg::EVENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_event),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   wsfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head_event),
      .head_valid         (!q_empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_fin            (rsp_fin),
      .rsp_rsv_bits       (rsp_rsv_bits),
      .rsp_opcode         (rsp_opcode),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .rsp_status_code    (rsp_status_code),
      .rsp_frame_error    (rsp_frame_error)
   );

endmodule

`default_nettype wire

[sv/wsfd_queue.sv]
// wsfd_queue: small register fifo between parser front and result back
// generic width and depth; no package use
`default_nettype none

module wsfd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

`default_nettype wire

[sv/wsfd_front.sv]
// wsfd_front: byte-at-a-time header parser, unmasking and close code capture
// uses wsfd_pkg for phase, kind and event types; holds the csr registers
`default_nettype none

module wsfd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 csr_write,
   input  wire logic                 csr_index,
   input  wire logic                 csr_wdata,
   output logic                      push,
   output wsfd_pkg::event_type       push_event
);

   wsfd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  first_ff, first_in;
   logic [6:0]  short_ff, short_in;
   logic [63:0] len_ff, len_in;
   logic        mask_ff, mask_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] left_ff, left_in;
   logic [1:0]  idx_ff, idx_in;
   logic [7:0]  close_hi_ff, close_hi_in;
   logic        close_pend_ff, close_pend_in;
   logic        unmask_ff, check_ff;

   logic        after_len;
   logic        finish;
   logic        hdr_err;
   logic [3:0]  op;
   logic [3:0]  need;
   logic [7:0]  key_byte;
   logic [7:0]  data;

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      short_in      = short_ff;
      len_in        = len_ff;
      mask_in       = mask_ff;
      key_in        = key_ff;
      left_in       = left_ff;
      idx_in        = idx_ff;
      close_hi_in   = close_hi_ff;
      close_pend_in = close_pend_ff;
      after_len     = 1'b0;
      finish        = 1'b0;
      push          = 1'b0;
      push_event    = '0;
      op            = first_ff[3:0];
      need          = (short_ff == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                        : wsfd_pkg::EXT64_BYTES;
      // key byte 0 sits in the top byte of the key
      key_byte      = key_ff[{~idx_ff, 3'b000} +: 8];
      data          = (unmask_ff && mask_ff) ? (in_byte ^ key_byte) : in_byte;

      if (accept) begin
         unique case (phase_ff)
            wsfd_pkg::PH_B0: begin
               first_in = in_byte;
               phase_in = wsfd_pkg::PH_B1;
            end
            wsfd_pkg::PH_B1: begin
               mask_in  = in_byte[7];
               short_in = in_byte[6:0];
               key_in   = '0;
               cnt_in   = '0;
               if (in_byte[6:0] <= wsfd_pkg::LEN_SHORT_MAX) begin
                  len_in    = {57'd0, in_byte[6:0]};
                  after_len = 1'b1;
               end else begin
                  len_in   = '0;
                  phase_in = wsfd_pkg::PH_EXT;
               end
            end
            wsfd_pkg::PH_EXT: begin
               len_in = {len_ff[55:0], in_byte};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_in >= need) begin
                  after_len = 1'b1;
               end
            end
            wsfd_pkg::PH_KEY: begin
               key_in = {key_ff[23:0], in_byte};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_in >= wsfd_pkg::KEY_BYTES) begin
                  cnt_in = '0;
                  finish = 1'b1;
               end
            end
            wsfd_pkg::PH_PAY: begin
               left_in                 = left_ff - 1'b1;
               push                    = 1'b1;
               push_event.kind         = wsfd_pkg::KIND_DATA;
               push_event.data_byte    = data;
               push_event.last         = (left_ff == 64'd1);
               if (close_pend_ff) begin
                  if (idx_ff == 2'd0) begin
                     close_hi_in = data;
                  end else begin
                     push_event.close_valid = 1'b1;
                     push_event.status_code = {close_hi_ff, data};
                     close_pend_in          = 1'b0;
                  end
               end
               idx_in = idx_ff + 1'b1;
               if (left_ff == 64'd1) begin
                  close_pend_in = 1'b0;
                  phase_in      = wsfd_pkg::PH_B0;
               end
            end
            default: begin
               phase_in = wsfd_pkg::PH_B0;
            end
         endcase
      end

      if (after_len) begin
         cnt_in = '0;
         if (mask_in) begin
            phase_in = wsfd_pkg::PH_KEY;
         end else begin
            finish = 1'b1;
         end
      end

      hdr_err = (op > wsfd_pkg::OP_MAX)
             || (op >= wsfd_pkg::OP_FIRST_RSVD && op <= wsfd_pkg::OP_LAST_RSVD)
             || (op >= wsfd_pkg::OP_CLOSE && short_in > wsfd_pkg::LEN_SHORT_MAX)
             || (op >= wsfd_pkg::OP_CLOSE && !first_ff[7]);

      if (finish) begin
         left_in                = len_in;
         idx_in                 = '0;
         close_pend_in          = (op == wsfd_pkg::OP_CLOSE);
         phase_in               = (len_in == '0) ? wsfd_pkg::PH_B0 : wsfd_pkg::PH_PAY;
         push                   = 1'b1;
         push_event.kind        = wsfd_pkg::KIND_HEADER;
         push_event.last        = (len_in == '0);
         push_event.frame_error = check_ff && hdr_err;
      end

      push_event.fin            = first_in[7];
      push_event.rsv_bits       = first_in[6:4];
      push_event.opcode         = first_in[3:0];
      push_event.masked         = mask_in;
      push_event.payload_length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= wsfd_pkg::PH_B0;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         close_pend_ff <= 1'b0;
         unmask_ff     <= 1'b1;
         check_ff      <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         close_pend_ff <= close_pend_in;
         if (csr_write && csr_index == wsfd_pkg::CSR_UNMASK) begin
            unmask_ff <= csr_wdata;
         end
         if (csr_write && csr_index == wsfd_pkg::CSR_CHECK) begin
            check_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      short_ff    <= short_in;
      len_ff      <= len_in;
      mask_ff     <= mask_in;
      key_ff      <= key_in;
      left_ff     <= left_in;
      close_hi_ff <= close_hi_in;
   end

endmodule

`default_nettype wire

[sv/wsfd_back.sv]
// wsfd_back: turns queued words into results, splitting off the close code
// uses wsfd_pkg event and kind types; drives the rsp output register
`default_nettype none

module wsfd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wsfd_pkg::event_type head,
   input  wire logic                head_valid,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic                     rsp_fin,
   output logic [2:0]               rsp_rsv_bits,
   output logic [3:0]               rsp_opcode,
   output logic                     rsp_masked,
   output logic [63:0]              rsp_payload_length,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_last,
   output logic [15:0]              rsp_status_code,
   output logic                     rsp_frame_error
);

   logic                valid_ff, valid_in;
   logic                second_ff, second_in;
   logic                load;
   wsfd_pkg::event_type out_ff, out_in;

   always_comb begin
      load      = head_valid && (!valid_ff || !rsp_stall);
      valid_in  = load || (valid_ff && rsp_stall);
      second_in = second_ff;
      pop       = 1'b0;
      out_in    = out_ff;
      if (load) begin
         out_in = head;
         if (second_ff) begin
            // close status word follows the data word of the same byte
            out_in.kind        = wsfd_pkg::KIND_CLOSE;
            out_in.data_byte   = '0;
            out_in.last        = 1'b0;
            out_in.frame_error = 1'b0;
            second_in          = 1'b0;
            pop                = 1'b1;
         end else begin
            out_in.status_code = '0;
            if (head.close_valid) begin
               second_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_fin            = out_ff.fin;
   assign rsp_rsv_bits       = out_ff.rsv_bits;
   assign rsp_opcode         = out_ff.opcode;
   assign rsp_masked         = out_ff.masked;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_last           = out_ff.last;
   assign rsp_status_code    = out_ff.status_code;
   assign rsp_frame_error    = out_ff.frame_error;

endmodule

`default_nettype wire

[sv/wsfd_checker.sv]
// wsfd_checker: port-level assertions for the deframer, bound to the top
// uses wsfd_pkg kind codes
`default_nettype none

module wsfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_kind,
   input wire logic [63:0] rsp_payload_length,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic        rsp_last,
   input wire logic [15:0] rsp_status_code,
   input wire logic        rsp_frame_error
);

   logic [1:0] prev_kind_ff;
   logic [7:0] prev_data_ff;

   // kind and data byte of the last word taken on rsp
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_kind_ff <= 2'(wsfd_pkg::KIND_HEADER);
         prev_data_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         prev_kind_ff <= rsp_kind;
         prev_data_ff <= rsp_data_byte;
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_status_code))
      else $error("rsp word changed while stalled");

   a_close_after_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 2'(wsfd_pkg::KIND_CLOSE) |->
         prev_kind_ff == 2'(wsfd_pkg::KIND_DATA)
         && prev_data_ff == rsp_status_code[7:0])
      else $error("close code not preceded by its data byte");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 2'(wsfd_pkg::KIND_HEADER) |->
         rsp_last == (rsp_payload_length == 64'd0)
         && rsp_data_byte == 8'd0 && rsp_status_code == 16'd0)
      else $error("header word fields inconsistent");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 2'(wsfd_pkg::KIND_DATA) |->
         rsp_status_code == 16'd0 && !rsp_frame_error)
      else $error("data word carries close code or error");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (.*);

`default_nettype wire

[dv/websocket_frame_deframer_core_tb.sv]
// testbench for websocket_frame_deframer_core: streams random and hand-built frames,
// predicts header, payload and close-status words and checks every rsp word in order
// depends on wsfd_pkg and the deframer rtl
`default_nettype none

module websocket_frame_deframer_core_tb;
   import wsfd_pkg::*;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef enum int {FORM_SHORT, FORM_16, FORM_64} len_form_t;

   typedef struct packed {
      kind_type    kind;
      logic        fin;
      logic [2:0]  rsv_bits;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [7:0]  data_byte;
      logic        last;
      logic [15:0] status_code;
      logic        frame_error;
   } deframed_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic        rsp_fin;
   logic [2:0]  rsp_rsv_bits;
   logic [3:0]  rsp_opcode;
   logic        rsp_masked;
   logic [63:0] rsp_payload_length;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last;
   logic [15:0] rsp_status_code;
   logic        rsp_frame_error;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic        csr_wdata = 1'b0;

   websocket_frame_deframer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_fin(rsp_fin), .rsp_rsv_bits(rsp_rsv_bits), .rsp_opcode(rsp_opcode),
      .rsp_masked(rsp_masked), .rsp_payload_length(rsp_payload_length),
      .rsp_data_byte(rsp_data_byte), .rsp_last(rsp_last),
      .rsp_status_code(rsp_status_code), .rsp_frame_error(rsp_frame_error),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // stream bytes still to send and words still to arrive
   logic [7:0]     byte_q[$];
   deframed_word_t expected_words[$];

   int errors = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   int words_seen = 0;
   int settings_run = 0;
   bit calm = 1'b0;

   // parser copy
   logic        do_unmask = 1'b1;
   logic        do_check  = 1'b1;
   phase_type   pp_phase = PH_B0;
   logic [3:0]  pp_count = '0;
   logic [7:0]  pp_first = '0;
   logic [6:0]  pp_short = '0;
   logic [63:0] pp_length = '0;
   logic        pp_mask = 1'b0;
   logic [31:0] pp_key = '0;
   logic [63:0] pp_left = '0;
   logic [1:0]  pp_index = '0;
   logic [7:0]  pp_close_hi = '0;
   logic        pp_close_pend = 1'b0;

   function automatic deframed_word_t frame_word(kind_type k);
      deframed_word_t w;
      w = '0;
      w.kind = k;
      w.fin = pp_first[7];
      w.rsv_bits = pp_first[6:4];
      w.opcode = pp_first[3:0];
      w.masked = pp_mask;
      w.payload_length = pp_length;
      return w;
   endfunction

   function automatic logic header_bad();
      logic [3:0] op;
      op = pp_first[3:0];
      if (op > OP_MAX) return 1'b1;
      if (op >= OP_FIRST_RSVD && op <= OP_LAST_RSVD) return 1'b1;
      if (op >= OP_CLOSE && pp_short > LEN_SHORT_MAX) return 1'b1;
      if (op >= OP_CLOSE && !pp_first[7]) return 1'b1;
      return 1'b0;
   endfunction

   task automatic emit_header();
      deframed_word_t w;
      w = frame_word(KIND_HEADER);
      w.last = (pp_length == 0);
      w.frame_error = do_check && header_bad();
      expected_words.push_back(w);
      pp_left = pp_length;
      pp_index = '0;
      pp_close_pend = (pp_first[3:0] == OP_CLOSE);
      pp_phase = (pp_length == 0) ? PH_B0 : PH_PAY;
   endtask

   task automatic length_done();
      pp_count = '0;
      if (pp_mask) pp_phase = PH_KEY;
      else emit_header();
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      deframed_word_t w;
      logic [7:0]  d;
      logic [31:0] key_shifted;
      logic [1:0]  idx;
      case (pp_phase)
         PH_B0: begin
            pp_first = b;
            pp_phase = PH_B1;
         end
         PH_B1: begin
            pp_mask = b[7];
            pp_short = b[6:0];
            pp_key = '0;
            pp_count = '0;
            if (pp_short <= LEN_SHORT_MAX) begin
               pp_length = {57'd0, pp_short};
               length_done();
            end else begin
               pp_length = '0;
               pp_phase = PH_EXT;
            end
         end
         PH_EXT: begin
            pp_length = {pp_length[55:0], b};
            pp_count = pp_count + 1'b1;
            if (pp_count >= ((pp_short == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES))
               length_done();
         end
         PH_KEY: begin
            pp_key = {pp_key[23:0], b};
            pp_count = pp_count + 1'b1;
            if (pp_count >= KEY_BYTES) begin
               pp_count = '0;
               emit_header();
            end
         end
         PH_PAY: begin
            idx = pp_index;
            d = b;
            if (do_unmask && pp_mask) begin
               key_shifted = pp_key >> (24 - 8 * idx);
               d = b ^ key_shifted[7:0];
            end
            pp_left = pp_left - 1'b1;
            w = frame_word(KIND_DATA);
            w.data_byte = d;
            w.last = (pp_left == 0);
            expected_words.push_back(w);
            if (pp_close_pend) begin
               if (idx == 2'd0) begin
                  pp_close_hi = d;
               end else begin
                  // status code rides right behind its second byte
                  w = frame_word(KIND_CLOSE);
                  w.status_code = {pp_close_hi, d};
                  expected_words.push_back(w);
                  pp_close_pend = 1'b0;
               end
            end
            pp_index = pp_index + 1'b1;
            if (pp_left == 0) begin
               pp_close_pend = 1'b0;
               pp_phase = PH_B0;
            end
         end
         default: pp_phase = PH_B0;
      endcase
   endtask

   // driver: one stream byte per handshake
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) deframe_byte(req_in_byte);
         if (!req_valid || !req_stall) begin
            if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
               req_in_byte <= byte_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic string word_text(deframed_word_t w);
      return $sformatf({"kind=%0d fin=%0b rsv=%0d op=%h mask=%0b len=%h ",
                        "data=%h last=%0b close=%h err=%0b"},
                       w.kind, w.fin, w.rsv_bits, w.opcode, w.masked, w.payload_length,
                       w.data_byte, w.last, w.status_code, w.frame_error);
   endfunction

   int  hold_left = 0;
   bit  hold_done = 1'b0;

   // monitor: checks each accepted rsp word against the oldest prediction
   always @(posedge clock) begin : monitor
      deframed_word_t seen;
      deframed_word_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.kind = kind_type'(rsp_kind);
            seen.fin = rsp_fin;
            seen.rsv_bits = rsp_rsv_bits;
            seen.opcode = rsp_opcode;
            seen.masked = rsp_masked;
            seen.payload_length = rsp_payload_length;
            seen.data_byte = rsp_data_byte;
            seen.last = rsp_last;
            seen.status_code = rsp_status_code;
            seen.frame_error = rsp_frame_error;
            words_seen++;
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected word: %s", $time, word_text(seen));
            end else begin
               want = expected_words.pop_front();
               if (seen !== want) begin
                  errors++;
                  $display("%0t: expected %s", $time, word_text(want));
                  $display("%0t: actual   %s", $time, word_text(seen));
               end
            end
         end
         // one long hold-off lets the block back up into its input
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && words_seen >= 200) begin
            hold_done = 1'b1;
            hold_left = 200;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 34);
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      byte_q.push_back(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic mask, input len_form_t form,
                             input logic [63:0] len, input int body);
      logic [6:0]  short_field;
      logic [31:0] key;
      case (form)
         FORM_SHORT: short_field = len[6:0];
         FORM_16:    short_field = LEN_EXT16;
         default:    short_field = LEN_EXT64;
      endcase
      key = $urandom;
      push_byte({fin, rsv, op});
      push_byte({mask, short_field});
      if (form == FORM_16) begin
         push_byte(len[15:8]);
         push_byte(len[7:0]);
      end else if (form == FORM_64) begin
         for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
      if (mask) for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
      for (int i = 0; i < body; i++) push_byte(8'($urandom_range(255)));
      frames_sent++;
   endtask

   task automatic send_random_frame();
      logic [3:0]  op;
      logic        fin;
      logic [2:0]  rsv;
      logic [63:0] len;
      len_form_t   form;
      int          r;
      if ($urandom_range(99) < 75) begin
         case ($urandom_range(5))
            0: op = OP_CONT;
            1: op = OP_TEXT;
            2: op = OP_BINARY;
            3: op = OP_CLOSE;
            4: op = OP_PING;
            default: op = OP_PONG;
         endcase
      end else begin
         op = 4'($urandom_range(15));
      end
      fin = (op >= OP_CLOSE) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
      rsv = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'd0;
      r = $urandom_range(99);
      form = FORM_SHORT;
      if (r < 65) begin
         len = 64'($urandom_range(12));
      end else if (r < 72) begin
         len = 64'($urandom_range(125, 110));
      end else if (r < 86) begin
         form = FORM_16;
         len = 64'($urandom_range(40));
      end else if (r < 96) begin
         form = FORM_64;
         len = 64'($urandom_range(20));
      end else begin
         len = '0;
      end
      // short close frames hit the missing and split status cases
      if (op == OP_CLOSE && form == FORM_SHORT && $urandom_range(1))
         len = 64'($urandom_range(3));
      send_frame(fin, rsv, op, 1'($urandom_range(1)), form, len, int'(len));
   endtask

   task automatic write_reg(input logic idx, input logic val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_UNMASK) do_unmask = val;
      else do_check = val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (byte_q.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [1:0] setting;
      int         target;
      // hand-built frames at the reset register values
      send_frame(1'b1, 3'd0, OP_TEXT, 1'b0, FORM_SHORT, 64'd0, 0);
      send_frame(1'b1, 3'd0, OP_BINARY, 1'b1, FORM_SHORT, 64'd3, 3);
      send_frame(1'b1, 3'd0, OP_CLOSE, 1'b0, FORM_SHORT, 64'd1, 1);
      send_frame(1'b1, 3'd0, OP_CLOSE, 1'b1, FORM_SHORT, 64'd2, 2);
      send_frame(1'b0, 3'd0, OP_PING, 1'b0, FORM_SHORT, 64'd0, 0);
      send_frame(1'b1, 3'd7, OP_FIRST_RSVD, 1'b0, FORM_SHORT, 64'd0, 0);
      send_frame(1'b0, 3'd5, 4'hF, 1'b0, FORM_SHORT, 64'd1, 1);
      send_frame(1'b1, 3'd0, OP_PING, 1'b0, FORM_16, 64'd1, 1);
      send_frame(1'b0, 3'd2, OP_CONT, 1'b1, FORM_64, 64'd2, 2);
      send_frame(1'b1, 3'd0, OP_TEXT, 1'b0, FORM_SHORT, 64'd125, 125);
      wait_drained();
      settings_run = 1;

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: setting = 2'b00;
            1: setting = 2'b10;
            2: setting = 2'b01;
            4: setting = 2'($urandom_range(3));
            default: setting = 2'b11;
         endcase
         write_reg(CSR_UNMASK, setting[1]);
         write_reg(CSR_CHECK, setting[0]);
         settings_run++;
         calm = (ph == 3);
         target = bytes_sent + ((ph == 3) ? 150 : 65);
         while (bytes_sent < target) send_random_frame();
         if (ph == 5) send_frame(1'b1, 3'd0, OP_BINARY, 1'b1, FORM_16, 64'd130, 130);
         wait_drained();
      end
      calm = 1'b0;

      // a length with its top bit set never completes, so it closes the run
      send_frame(1'b1, 3'd0, OP_BINARY, 1'b1, FORM_64, 64'h8000_0000_0000_0005, 6);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("sent %0d frames in %0d stream bytes over %0d register settings",
               frames_sent, bytes_sent, settings_run);
      $display("checked %0d result words, %0d errors", words_seen, errors);
      if (errors == 0) begin
         $display("websocket_frame_deframer_core: match");
      end else begin
         $display("websocket_frame_deframer_core: mismatch");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout with %0d words outstanding", expected_words.size());
      $display("websocket_frame_deframer_core: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
